>>> rtl/cpm_directory_file_merge_unit_assert.svh
// Assertion macros for the directory file merge unit.
// Both macros sample on clk and are disabled while rst is high.
`ifndef CPM_DIRECTORY_FILE_MERGE_UNIT_ASSERT_SVH
`define CPM_DIRECTORY_FILE_MERGE_UNIT_ASSERT_SVH

// Same-cycle implication
`define CDFM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define CDFM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/cdfm_pkg.sv
// ----------------------------------------------------------------------------
// cdfm_pkg
// Shared types, constants and key helper for the directory file merge unit.
// ----------------------------------------------------------------------------
package cdfm_pkg;

  // Default sizing
  localparam int TABLE_DEPTH_DEF     = 64;
  localparam int MAX_DIR_ENTRIES_DEF = 512;

  // Directory entry constants
  localparam logic [7:0] DELETED_MARK  = 8'hE5;
  localparam logic [7:0] MAX_USER      = 8'd15;
  localparam logic [6:0] SPACE_CHAR    = 7'h20;
  localparam int         EXT_FIELD_CAP = 1023;
  localparam logic [23:0] BYTE_CAP     = 24'hFF_FFFF;
  localparam logic [6:0] FILE_LIMIT_RST = 7'd64;

  // Result status codes
  typedef enum logic [2:0] {
    ST_DELETED  = 3'd0,
    ST_BAD_USER = 3'd1,
    ST_NEW      = 3'd2,
    ST_MERGED   = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // Configuration register indexes
  typedef enum logic {
    REG_FILE_LIMIT = 1'b0,
    REG_WIDE_PTR   = 1'b1
  } cfg_reg_t;

  // Control states of the top level
  typedef enum logic {
    S_IDLE = 1'b0,
    S_RUN  = 1'b1
  } state_t;

  // Search word handed from cell to cell
  typedef struct packed {
    logic        valid;
    logic        hit;
    logic        created;
    logic [3:0]  user;
    logic [55:0] name_key;
    logic [20:0] ext_key;
    logic [7:0]  records;
    logic [15:0] head_block;
    logic [2:0]  attrs;
    logic [5:0]  slot;
    logic [9:0]  extents;
    logic [23:0] bytes;
  } tok_t;

  // Pack up to count characters into 7-bit codes, zero from the first space on
  function automatic logic [55:0] make_key(logic [63:0] chars, int unsigned count);
    logic [55:0] key;
    logic        stop;
    logic [6:0]  c;
    key  = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      c = chars[8*i +: 7];
      if (i >= count || c == SPACE_CHAR) stop = 1'b1;
      if (!stop) key[7*i +: 7] = c;
    end
    return key;
  endfunction

endpackage

>>> rtl/cpm_directory_file_merge_unit.sv
// ----------------------------------------------------------------------------
// cpm_directory_file_merge_unit
// Folds directory entries into a file table held in a row of slot cells.
//
//  Channel   Handshake            Words
//  input     start / busy         one directory entry
//  result    done (one cycle)     one status word per entry
//  config    cfg_we               file_limit, wide_block_pointers
//
// A live entry travels the cell row, one cell a cycle, and its result is
// registered once it leaves the last cell; busy is high while it travels.
// The next entry can be taken while the result shows, but no new entry is
// taken while a live one is still in the row.
// Deleted, bad-user and table-full entries answer on the next cycle and
// keep busy low. Reset empties the table at once.
// done is shown for one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`include "cpm_directory_file_merge_unit_assert.svh"

module cpm_directory_file_merge_unit #(
  parameter int TABLE_DEPTH     = cdfm_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_DIR_ENTRIES = cdfm_pkg::MAX_DIR_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  // entry
  input  logic        start,
  output logic        busy,
  input  logic        start_of_directory,
  input  logic [7:0]  user_byte,
  input  logic [63:0] name_chars,
  input  logic [23:0] ext_chars,
  input  logic [7:0]  rec_count,
  input  logic [7:0]  alloc_low,
  input  logic [7:0]  alloc_high,
  // result
  output logic        done,
  output logic [2:0]  status,
  output logic [5:0]  file_index,
  output logic [9:0]  extent_total,
  output logic [23:0] byte_total,
  output logic [15:0] head_block,
  output logic        read_only_flag,
  output logic        system_flag,
  output logic        archived_flag,
  output logic [6:0]  files_held
);
  import cdfm_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int LIM_W = (CNT_W > 7) ? CNT_W : 7;

  // Config registers
  logic [6:0] file_limit;
  logic       wide_block_pointers;

  // Control
  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] file_total;
  logic [CNT_W-1:0] file_total_next;
  logic             accept;
  logic             full;
  logic [LIM_W-1:0] limit_eff;
  logic [CNT_W-1:0] total_eff;
  logic [55:0]      ext_key_wide;
  tok_t             inject;
  tok_t             chain [TABLE_DEPTH];
  tok_t             last;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      file_limit          <= FILE_LIMIT_RST;
      wide_block_pointers <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILE_LIMIT: file_limit          <= cfg_data;
        REG_WIDE_PTR:   wide_block_pointers <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign busy   = (state == S_RUN);
  assign accept = start && !busy;
  assign last   = chain[TABLE_DEPTH-1];

  // Entry classification and search word
  always_comb begin
    total_eff = start_of_directory ? '0 : file_total;
    limit_eff = (LIM_W'(file_limit) < LIM_W'(TABLE_DEPTH)) ?
                LIM_W'(file_limit) : LIM_W'(TABLE_DEPTH);
    full      = LIM_W'(total_eff) >= limit_eff;
    ext_key_wide = make_key({40'b0, ext_chars}, 3);

    inject             = '0;
    inject.user        = user_byte[3:0];
    inject.name_key    = make_key(name_chars, 8);
    inject.ext_key     = ext_key_wide[20:0];
    inject.records     = rec_count;
    inject.head_block  = wide_block_pointers ? {alloc_high, alloc_low}
                                             : {8'h00, alloc_low};
    inject.attrs       = {ext_chars[23], ext_chars[15], ext_chars[7]};
    inject.valid       = accept && !full && (user_byte != DELETED_MARK)
                         && (user_byte <= MAX_USER);
  end

  // Cell row; the head cell sees the count as cleared by a directory start
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      cdfm_cell #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .MAX_DIR_ENTRIES(MAX_DIR_ENTRIES),
        .CELL_INDEX     (i),
        .CNT_W          (CNT_W)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .file_total(total_eff),
        .tok_in    (inject),
        .tok_out   (chain[i])
      );
    end else begin : g_body
      cdfm_cell #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .MAX_DIR_ENTRIES(MAX_DIR_ENTRIES),
        .CELL_INDEX     (i),
        .CNT_W          (CNT_W)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .file_total(file_total),
        .tok_in    (chain[i-1]),
        .tok_out   (chain[i])
      );
    end
  end

  // Next state and file count
  always_comb begin
    state_next      = state;
    file_total_next = file_total;
    case (state)
      S_IDLE: begin
        if (accept) begin
          file_total_next = total_eff;
          if (inject.valid) state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (last.valid) begin
          state_next = S_IDLE;
          if (last.created) file_total_next = file_total + CNT_W'(1);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      file_total <= '0;
    end else begin
      state      <= state_next;
      file_total <= file_total_next;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && !inject.valid) || (busy && last.valid);
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (busy && last.valid) begin
      status         <= last.created ? ST_NEW : ST_MERGED;
      file_index     <= last.slot;
      extent_total   <= last.extents;
      byte_total     <= last.bytes;
      head_block     <= last.head_block;
      read_only_flag <= last.attrs[0];
      system_flag    <= last.attrs[1];
      archived_flag  <= last.attrs[2];
      files_held     <= 7'(file_total_next);
    end else if (accept && !inject.valid) begin
      if (full) begin
        status <= ST_FULL;
      end else if (user_byte == DELETED_MARK) begin
        status <= ST_DELETED;
      end else begin
        status <= ST_BAD_USER;
      end
      file_index     <= '0;
      extent_total   <= '0;
      byte_total     <= '0;
      head_block     <= '0;
      read_only_flag <= 1'b0;
      system_flag    <= 1'b0;
      archived_flag  <= 1'b0;
      files_held     <= 7'(total_eff);
    end
  end

  // Checks
  `CDFM_ASSERT_IMP(a_done_idle, done, !busy, "result shown while search still running")
  `CDFM_ASSERT_IMP(a_row_hit, last.valid, last.hit, "search word left the row unplaced")
  `CDFM_ASSERT_NXT(a_dir_clear, accept && start_of_directory, file_total == '0, "directory start did not empty table")
  `CDFM_ASSERT_IMP(a_count_bound, 1'b1, file_total <= CNT_W'(TABLE_DEPTH), "file count past table depth")

endmodule

>>> rtl/cdfm_cell.sv
// ----------------------------------------------------------------------------
// cdfm_cell
// One table slot. Compares the passing search word against its entry,
// merges on a hit, creates the entry when it is the first free slot.
// ----------------------------------------------------------------------------
module cdfm_cell #(
  parameter int TABLE_DEPTH     = cdfm_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_DIR_ENTRIES = cdfm_pkg::MAX_DIR_ENTRIES_DEF,
  parameter int CELL_INDEX      = 0,
  parameter int CNT_W           = $clog2(TABLE_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [CNT_W-1:0]  file_total,
  input  cdfm_pkg::tok_t    tok_in,
  output cdfm_pkg::tok_t    tok_out
);
  import cdfm_pkg::*;

  localparam int         EXT_CAP   = (MAX_DIR_ENTRIES < EXT_FIELD_CAP) ?
                                     MAX_DIR_ENTRIES : EXT_FIELD_CAP;
  localparam logic [9:0] EXT_CAP_V = 10'(EXT_CAP);
  localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(CELL_INDEX);

  // Slot storage
  logic [3:0]  user;
  logic [55:0] name_key;
  logic [20:0] ext_key;
  logic [9:0]  extents;
  logic [23:0] bytes;
  logic [15:0] head_block;
  logic [2:0]  attrs;

  logic        live;
  logic        match;
  logic        create;
  logic [9:0]  extents_next;
  logic [23:0] bytes_next;
  logic [24:0] byte_sum;
  tok_t        tok_next;

  // Compare and merge
  always_comb begin
    live     = tok_in.valid && !tok_in.hit;
    match    = live && (MY_INDEX < file_total) && (user == tok_in.user)
               && (name_key == tok_in.name_key) && (ext_key == tok_in.ext_key);
    create   = live && (MY_INDEX == file_total);
    byte_sum = {1'b0, bytes} + 25'({tok_in.records, 7'b0});
    extents_next = (extents < EXT_CAP_V) ? extents + 10'd1 : extents;
    bytes_next   = byte_sum[24] ? BYTE_CAP : byte_sum[23:0];

    tok_next = tok_in;
    if (match) begin
      tok_next.hit        = 1'b1;
      tok_next.slot       = 6'(CELL_INDEX);
      tok_next.extents    = extents_next;
      tok_next.bytes      = bytes_next;
      tok_next.head_block = head_block;
      tok_next.attrs      = attrs;
    end else if (create) begin
      tok_next.hit     = 1'b1;
      tok_next.created = 1'b1;
      tok_next.slot    = 6'(CELL_INDEX);
      tok_next.extents = (EXT_CAP_V > 10'd1) ? 10'd1 : EXT_CAP_V;
      tok_next.bytes   = 24'({tok_in.records, 7'b0});
    end
  end

  // Slot write
  always_ff @(posedge clk) begin
    if (match) begin
      extents <= extents_next;
      bytes   <= bytes_next;
    end else if (create) begin
      user       <= tok_in.user;
      name_key   <= tok_in.name_key;
      ext_key    <= tok_in.ext_key;
      extents    <= tok_next.extents;
      bytes      <= tok_next.bytes;
      head_block <= tok_in.head_block;
      attrs      <= tok_in.attrs;
    end
  end

  // Hand the word to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

>>> tb/cpm_directory_file_merge_checker.sv
// ----------------------------------------------------------------------------
// cpm_directory_file_merge_checker
// Watches the entry, config and result ports of the directory merge unit,
// keeps its own file table, and checks every result word against it.
// ----------------------------------------------------------------------------
module cpm_directory_file_merge_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        start,
  input  logic        busy,
  input  logic        start_of_directory,
  input  logic [7:0]  user_byte,
  input  logic [63:0] name_chars,
  input  logic [23:0] ext_chars,
  input  logic [7:0]  rec_count,
  input  logic [7:0]  alloc_low,
  input  logic [7:0]  alloc_high,
  input  logic        done,
  input  logic [2:0]  status,
  input  logic [5:0]  file_index,
  input  logic [9:0]  extent_total,
  input  logic [23:0] byte_total,
  input  logic [15:0] head_block,
  input  logic        read_only_flag,
  input  logic        system_flag,
  input  logic        archived_flag,
  input  logic [6:0]  files_held,
  output int          errors,
  output int          outstanding,
  output int          n_new,
  output int          n_merged,
  output int          n_full,
  output int          n_skipped
);
  import cdfm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS        = TABLE_DEPTH_DEF;
  localparam int EXTENT_CAP   = (MAX_DIR_ENTRIES_DEF < EXT_FIELD_CAP) ?
                                MAX_DIR_ENTRIES_DEF : EXT_FIELD_CAP;
  localparam int RECORD_BYTES = 128;
  localparam int PRINT_CAP    = 40;

  // One result word as the block should present it
  typedef struct packed {
    status_t     status;
    logic [5:0]  idx;
    logic [9:0]  extents;
    logic [23:0] bytes;
    logic [15:0] fblock;
    logic        ro;
    logic        sys;
    logic        arc;
    logic [6:0]  held;
  } file_word_t;

  // Shadow file table and registers
  logic [3:0]  tab_user   [SLOTS];
  logic [55:0] tab_name   [SLOTS];
  logic [20:0] tab_ext    [SLOTS];
  int unsigned tab_extents[SLOTS];
  int unsigned tab_bytes  [SLOTS];
  logic [15:0] tab_fblock [SLOTS];
  logic [2:0]  tab_attr   [SLOTS];
  int unsigned files;
  int unsigned limit_reg;
  logic        wide_reg;

  file_word_t expected_words[$];

  // 7-bit key: attribute bit dropped, everything from the first space zeroed
  function automatic logic [55:0] fold_chars(logic [63:0] chars, int n);
    logic [55:0] k;
    logic [6:0]  c;
    logic        ended;
    k     = '0;
    ended = 1'b0;
    for (int i = 0; i < n; i++) begin
      c = chars[8*i +: 7];
      if (c == SPACE_CHAR) ended = 1'b1;
      if (!ended) k[7*i +: 7] = c;
    end
    return k;
  endfunction

  // Fold one directory entry into the shadow table, return its result word
  function automatic file_word_t absorb_entry(logic sod, logic [7:0] usr,
                                              logic [63:0] nm, logic [23:0] ex,
                                              logic [7:0] recs, logic [7:0] lo,
                                              logic [7:0] hi);
    file_word_t  w;
    logic [55:0] nkey;
    logic [20:0] ekey;
    int unsigned cap;
    int unsigned sum;
    int          slot;
    w    = '0;
    cap  = (limit_reg < SLOTS) ? limit_reg : SLOTS;
    slot = -1;
    if (sod) files = 0;
    // full check wins over the deleted and user checks
    if (files >= cap) w.status = ST_FULL;
    else if (usr == DELETED_MARK) w.status = ST_DELETED;
    else if (usr > MAX_USER) w.status = ST_BAD_USER;
    else begin
      nkey = fold_chars(nm, 8);
      ekey = 21'(fold_chars({40'd0, ex}, 3));
      for (int i = 0; i < files; i++)
        if (slot < 0 && tab_user[i] == usr[3:0] && tab_name[i] == nkey &&
            tab_ext[i] == ekey) slot = i;
      if (slot >= 0) begin
        // merge: counters saturate
        if (tab_extents[slot] < EXTENT_CAP) tab_extents[slot]++;
        sum = tab_bytes[slot] + int'(recs) * RECORD_BYTES;
        tab_bytes[slot] = (sum > BYTE_CAP) ? BYTE_CAP : sum;
        w.status = ST_MERGED;
      end else begin
        slot              = files;
        tab_user[slot]    = usr[3:0];
        tab_name[slot]    = nkey;
        tab_ext[slot]     = ekey;
        tab_extents[slot] = 1;
        tab_bytes[slot]   = int'(recs) * RECORD_BYTES;
        tab_fblock[slot]  = wide_reg ? {hi, lo} : {8'h00, lo};
        tab_attr[slot]    = {ex[23], ex[15], ex[7]};
        files++;
        w.status = ST_NEW;
      end
      w.idx     = 6'(slot);
      w.extents = 10'(tab_extents[slot]);
      w.bytes   = 24'(tab_bytes[slot]);
      w.fblock  = tab_fblock[slot];
      w.ro      = tab_attr[slot][0];
      w.sys     = tab_attr[slot][1];
      w.arc     = tab_attr[slot][2];
    end
    w.held = 7'(files);
    return w;
  endfunction

  function automatic void check_field(string what, logic [23:0] want,
                                      logic [23:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= PRINT_CAP)
        $display("%0t: %s expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  // Compare results first, then take config writes and new entries
  always @(posedge clk) begin : watch
    file_word_t want;
    if (rst) begin
      files     = 0;
      limit_reg = FILE_LIMIT_RST;
      wide_reg  = 1'b0;
      errors    = 0;
      n_new     = 0;
      n_merged  = 0;
      n_full    = 0;
      n_skipped = 0;
      expected_words.delete();
    end else begin
      if (done) begin
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= PRINT_CAP)
            $display("%0t: result word with none expected, status %0d", $time, status);
        end else begin
          want = expected_words.pop_front();
          check_field("status", want.status, status);
          check_field("file_index", want.idx, file_index);
          check_field("extent_total", want.extents, extent_total);
          check_field("byte_total", want.bytes, byte_total);
          check_field("head_block", want.fblock, head_block);
          check_field("read_only_flag", want.ro, read_only_flag);
          check_field("system_flag", want.sys, system_flag);
          check_field("archived_flag", want.arc, archived_flag);
          check_field("files_held", want.held, files_held);
          case (want.status)
            ST_NEW:    n_new++;
            ST_MERGED: n_merged++;
            ST_FULL:   n_full++;
            default:   n_skipped++;
          endcase
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_FILE_LIMIT: limit_reg = cfg_data;
          REG_WIDE_PTR:   wide_reg  = cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy)
        expected_words.push_back(absorb_entry(start_of_directory, user_byte,
                                              name_chars, ext_chars, rec_count,
                                              alloc_low, alloc_high));
    end
    outstanding <= expected_words.size();
  end

endmodule

>>> tb/tb_cpm_directory_file_merge_unit.sv
// ----------------------------------------------------------------------------
// tb_cpm_directory_file_merge_unit
// Feeds directory scans to the merge unit: a directed set of corner entries,
// then random scans of repeating files mixed with deleted, bad-user and raw
// entries, under changing limits and pointer modes and with sender gaps.
// ----------------------------------------------------------------------------
module tb_cpm_directory_file_merge_unit;
  import cdfm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // One directory entry as driven on the ports
  typedef struct packed {
    logic        sod;
    logic [7:0]  user;
    logic [63:0] name;
    logic [23:0] ext;
    logic [7:0]  recs;
    logic [7:0]  lo;
    logic [7:0]  hi;
  } dir_entry_t;

  // A file of a scan: its key characters, reused for every extent
  typedef struct {
    logic [3:0]      user;
    int              nlen;
    int              elen;
    logic [7:0][6:0] nch;
    logic [2:0][6:0] ech;
  } file_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [6:0]  cfg_data = '0;
  logic        start = 1'b0;
  logic        busy;
  logic        start_of_directory = 1'b0;
  logic [7:0]  user_byte = '0;
  logic [63:0] name_chars = '0;
  logic [23:0] ext_chars = '0;
  logic [7:0]  rec_count = '0;
  logic [7:0]  alloc_low = '0;
  logic [7:0]  alloc_high = '0;
  logic        done;
  logic [2:0]  status;
  logic [5:0]  file_index;
  logic [9:0]  extent_total;
  logic [23:0] byte_total;
  logic [15:0] head_block;
  logic        read_only_flag;
  logic        system_flag;
  logic        archived_flag;
  logic [6:0]  files_held;

  int errors, outstanding, n_new, n_merged, n_full, n_skipped;
  int sender_idle = 0;
  int items_sent = 0;

  always #4 clk = ~clk;

  cpm_directory_file_merge_unit uut (.*);

  cpm_directory_file_merge_checker checker_i (.*);

  // Present one entry and hold it until the block takes it
  task automatic send_entry(input dir_entry_t e);
    while ($urandom_range(99) < sender_idle) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start              <= 1'b1;
    start_of_directory <= e.sod;
    user_byte          <= e.user;
    name_chars         <= e.name;
    ext_chars          <= e.ext;
    rec_count          <= e.recs;
    alloc_low          <= e.lo;
    alloc_high         <= e.hi;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_fields(logic sod, logic [7:0] usr, logic [63:0] nm,
                             logic [63:0] ex, logic [7:0] recs, logic [7:0] lo,
                             logic [7:0] hi);
    send_entry({sod, usr, nm, ex[23:0], recs, lo, hi});
  endtask

  // Stop sending and wait for every outstanding word
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [6:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic shuffle_config();
    logic [6:0] lim;
    case ($urandom_range(5))
      0:       lim = 7'd1;
      1:       lim = FILE_LIMIT_RST;
      2:       lim = 7'($urandom_range(2, 63));
      3:       lim = 7'($urandom_range(65, 127));
      4:       lim = 7'd0;
      default: lim = 7'($urandom_range(1, 12));
    endcase
    write_reg(REG_FILE_LIMIT, lim);
    // upper data bits are don't-care for the pointer mode
    write_reg(REG_WIDE_PTR, 7'($urandom));
  endtask

  // Space-padded text, first character in the low byte
  function automatic logic [63:0] text_chars(string s);
    logic [63:0] v;
    v = {8{8'h20}};
    for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  function automatic logic [6:0] pick_char();
    logic [6:0] c;
    c = ($urandom_range(7) == 0) ? 7'($urandom) : 7'($urandom_range(33, 90));
    if (c == SPACE_CHAR) c = 7'h5F;
    return c;
  endfunction

  function automatic file_t new_file();
    file_t f;
    f.user = 4'($urandom);
    f.nlen = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 8);
    f.elen = $urandom_range(3);
    for (int i = 0; i < 8; i++) f.nch[i] = pick_char();
    for (int i = 0; i < 3; i++) f.ech[i] = pick_char();
    return f;
  endfunction

  // Same key every time: random attribute bits, plain or marked space,
  // junk after the terminator
  function automatic logic [63:0] render_field(logic [7:0][6:0] ch, int len, int n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++) begin
      if (i < len) v[8*i +: 8] = {1'($urandom), ch[i]};
      else if (i == len) v[8*i +: 8] = {1'($urandom), SPACE_CHAR};
      else v[8*i +: 8] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h20;
    end
    return v;
  endfunction

  function automatic dir_entry_t file_entry(file_t f);
    dir_entry_t e;
    e.sod  = 1'b0;
    e.user = {4'd0, f.user};
    e.name = render_field(f.nch, f.nlen, 8);
    e.ext  = 24'(render_field({35'd0, f.ech}, f.elen, 3));
    e.recs = ($urandom_range(5) == 0) ? 8'hFF : 8'($urandom);
    e.lo   = 8'($urandom);
    e.hi   = 8'($urandom);
    return e;
  endfunction

  // One directory scan over a pool of files, with noise mixed in
  task automatic run_scan(int n_files, int n_entries);
    file_t      pool[$];
    file_t      f;
    dir_entry_t e;
    int         r;
    int         j;
    for (int k = 0; k < n_files; k++) begin
      f = new_file();
      // near twins: same name, other user or other extension
      if (k > 0 && $urandom_range(3) == 0) begin
        f = pool[k - 1];
        if ($urandom_range(1)) f.user = f.user + 4'd1;
        else f.elen = (f.elen + 1) % 4;
      end
      pool.push_back(f);
    end
    for (int i = 0; i < n_entries; i++) begin
      r = $urandom_range(99);
      if (r < 78) begin
        j = $urandom_range(1) ? (i % n_files) : $urandom_range(n_files - 1);
        e = file_entry(pool[j]);
      end else begin
        e.name = {$urandom, $urandom};
        e.ext  = 24'($urandom);
        e.recs = 8'($urandom);
        e.lo   = 8'($urandom);
        e.hi   = 8'($urandom);
        if (r < 88) e.user = DELETED_MARK;
        else if (r < 94) e.user = 8'($urandom_range(16, 255));
        else e.user = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(15));
      end
      // mostly a clean start; sometimes none, rarely a restart mid-scan
      e.sod = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(199) == 0);
      send_entry(e);
    end
  endtask

  task automatic run_phase(int idle, int quota);
    int target;
    int nf;
    target = items_sent + quota;
    while (items_sent < target) begin
      if ($urandom_range(2) == 0) shuffle_config();
      sender_idle = ($urandom_range(4) == 0) ? 0 : idle;
      if ($urandom_range(9) == 0) begin
        // a file pool near or past the table depth
        nf = $urandom_range(60, 80);
        run_scan(nf, nf + $urandom_range(5, 25));
      end else begin
        nf = $urandom_range(1, 12);
        run_scan(nf, $urandom_range(8, 40));
      end
    end
  endtask

  // One file merged long enough to pin both counters at their caps
  task automatic run_long_file(int n_entries);
    file_t      f;
    dir_entry_t e;
    f = new_file();
    for (int i = 0; i < n_entries; i++) begin
      e      = file_entry(f);
      e.sod  = (i == 0);
      e.recs = ($urandom_range(15) == 0) ? 8'($urandom) : 8'hFF;
      send_entry(e);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: sod, user, name, ext, records, alloc low, alloc high
    send_fields(1, 8'h00, text_chars("FILE"), text_chars("TXT"), 8'd0, 8'hFF, 8'hAA);
    send_fields(0, 8'h00, text_chars("FILE") | {8{8'h80}}, text_chars("TXT") | {8{8'h80}},
                8'd255, 8'h01, 8'h02);
    send_fields(0, DELETED_MARK, '1, '1, 8'hFF, 8'hFF, 8'hFF);
    send_fields(0, 8'd16, text_chars("FILE"), text_chars("TXT"), 8'd1, 8'h00, 8'h00);
    send_fields(0, 8'hFF, '0, '0, 8'd0, 8'h00, 8'h00);
    send_fields(0, MAX_USER, '1, '1, 8'hFF, 8'hFF, 8'hFF);
    // marked space ends the name; junk after it is ignored
    send_fields(0, 8'h00, 64'h5A5958A0_454C4946, text_chars("TXT"), 8'd7, 8'h10, 8'h20);
    // periods inside fields: keys differ although the joined text matches
    send_fields(0, 8'h00, text_chars("A.B"), text_chars("C"), 8'd3, 8'h05, 8'h06);
    send_fields(0, 8'h00, text_chars("A"), text_chars("B.C"), 8'd3, 8'h07, 8'h08);
    // blank name and all-zero name share the zero key
    send_fields(0, 8'd3, text_chars(""), text_chars(""), 8'd1, 8'h09, 8'h0A);
    send_fields(0, 8'd3, '0, '0, 8'd2, 8'h0B, 8'h0C);
    send_fields(0, 8'd1, text_chars("FILE"), text_chars("TXT"), 8'd1, 8'h0D, 8'h0E);
    write_reg(REG_WIDE_PTR, 7'd1);
    send_fields(0, 8'd2, text_chars("WIDE"), text_chars("BIN"), 8'd200, 8'h34, 8'h12);
    send_fields(0, 8'd2, text_chars("WIDE"), text_chars("BIN"), 8'd255, 8'h56, 8'h78);
    // zero limit: always full, even ahead of the deleted check
    write_reg(REG_FILE_LIMIT, 7'd0);
    send_fields(0, 8'd2, text_chars("WIDE"), text_chars("BIN"), 8'd1, 8'h00, 8'h00);
    send_fields(0, DELETED_MARK, '0, '0, 8'd0, 8'h00, 8'h00);
    // limit above the table depth acts as the depth
    write_reg(REG_FILE_LIMIT, 7'd127);
    send_fields(1, 8'd4, text_chars("NEW"), text_chars("COM"), 8'd0, 8'h11, 8'h22);
    write_reg(REG_FILE_LIMIT, 7'd2);
    send_fields(0, 8'd5, text_chars("TWO"), text_chars("DAT"), 8'd9, 8'h33, 8'h44);
    // full table turns away an entry that would have merged
    send_fields(0, 8'd4, text_chars("NEW"), text_chars("COM"), 8'd9, 8'h55, 8'h66);
    send_fields(1, 8'd6, text_chars("RST"), text_chars("SUB"), 8'd4, 8'h77, 8'h88);
    write_reg(REG_FILE_LIMIT, FILE_LIMIT_RST);
    write_reg(REG_WIDE_PTR, 7'd0);

    // random scans
    run_phase(38, 380);
    run_phase(82, 330);
    sender_idle = 0;
    write_reg(REG_FILE_LIMIT, FILE_LIMIT_RST);
    run_long_file(560);
    run_phase(0, 150);

    settle();
    repeat (70) @(posedge clk);
    $display("%0d directory entries sent across limit and pointer-mode changes",
             items_sent);
    $display("words checked: %0d new, %0d merged, %0d table full, %0d skipped",
             n_new, n_merged, n_full, n_skipped);
    if (errors == 0 && outstanding == 0) begin
      $display("cpm_directory_file_merge_unit: match");
    end else begin
      $display("cpm_directory_file_merge_unit: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("cpm_directory_file_merge_unit: mismatch");
    $finish;
  end

endmodule

>>> cpm_directory_file_merge_unit.f
+incdir+rtl
rtl/cdfm_pkg.sv
rtl/cdfm_cell.sv
rtl/cpm_directory_file_merge_unit.sv
tb/cpm_directory_file_merge_checker.sv
tb/tb_cpm_directory_file_merge_unit.sv
